/* rtl/mlr_pkg.sv */
// shared types and codes for the midpoint line rasterizer
`timescale 1ns / 1ps

package mlr_pkg;

	// request codes carried in req_type
	typedef enum logic {
		REQ_START = 1'b0,
		REQ_STEP  = 1'b1
	} req_t;

	// control part of a queued command, from the front end to the line engine
	typedef struct packed {
		logic is_start;
		logic x_neg;
		logic y_neg;
		logic y_major;
	} cmd_ctrl_t;

	localparam int CMD_CTRL_BITS = $bits(cmd_ctrl_t);

endpackage

/* rtl/mlr_fifo.sv */
// small register queue with full and empty flags
`timescale 1ns / 1ps

module mlr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             wr_do;
	logic             rd_do;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign wr_do   = wr_en && !full;
	assign rd_do   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (wr_do) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_do) begin
				if (wr_ptr_q == AW'(DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (rd_do) begin
				if (rd_ptr_q == AW'(DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (wr_do && !rd_do) begin
				count_q <= count_q + 1'b1;
			end else if (rd_do && !wr_do) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/mlr_front.sv */
// front end: classifies requests and sets up octant, major and minor deltas
`timescale 1ns / 1ps

module mlr_front
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output cmd_ctrl_t             cmd_ctrl,
	output logic [COORD_BITS-1:0] cmd_x,
	output logic [COORD_BITS-1:0] cmd_y,
	output logic [COORD_BITS-1:0] cmd_major,
	output logic [COORD_BITS-1:0] cmd_minor
);

	localparam int C = COORD_BITS;

	logic [C:0]   dx;
	logic [C:0]   dy;
	logic [C-1:0] adx;
	logic [C-1:0] ady;
	logic         y_major;

	// signed deltas with one extra bit, then magnitudes
	always_comb begin
		dx = {end_x[C-1], end_x} - {start_x[C-1], start_x};
		dy = {end_y[C-1], end_y} - {start_y[C-1], start_y};
		adx = dx[C] ? C'(-dx) : dx[C-1:0];
		ady = dy[C] ? C'(-dy) : dy[C-1:0];
		y_major = ady > adx;
	end

	// command for the line engine
	always_comb begin
		cmd_ctrl.is_start = (req_t'(req_type) == REQ_START);
		cmd_ctrl.x_neg    = dx[C];
		cmd_ctrl.y_neg    = dy[C];
		cmd_ctrl.y_major  = y_major;
		cmd_x             = start_x;
		cmd_y             = start_y;
		cmd_major         = y_major ? ady : adx;
		cmd_minor         = y_major ? adx : ady;
	end

endmodule

/* rtl/mlr_back.sv */
// line engine: runs the midpoint decision and produces one pixel per start and per step of a line in progress
`timescale 1ns / 1ps

module mlr_back
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_empty,
	output logic                  cmd_pop,
	input  cmd_ctrl_t             cmd_ctrl,
	input  logic [COORD_BITS-1:0] cmd_x,
	input  logic [COORD_BITS-1:0] cmd_y,
	input  logic [COORD_BITS-1:0] cmd_major,
	input  logic [COORD_BITS-1:0] cmd_minor,
	input  logic                  out_full,
	output logic                  out_wr,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic                  out_last
);

	localparam int C  = COORD_BITS;
	localparam int DW = COORD_BITS + 3;

	logic          busy_q;
	logic [C-1:0]  cur_x_q;
	logic [C-1:0]  cur_y_q;
	logic [C-1:0]  steps_q;
	logic [DW-1:0] dec_q;
	logic [DW-1:0] inc_move_q;
	logic [DW-1:0] inc_stay_q;
	logic          x_neg_q;
	logic          y_neg_q;
	logic          y_major_q;

	logic [DW-1:0] minor2;
	logic [DW-1:0] major2;
	logic          move_minor;
	logic [C-1:0]  nx;
	logic [C-1:0]  ny;
	logic          do_start;
	logic          do_step;

	// take a command only when the result queue has room
	assign cmd_pop  = !cmd_empty && !out_full;
	assign do_start = cmd_pop && cmd_ctrl.is_start;
	assign do_step  = cmd_pop && !cmd_ctrl.is_start && busy_q;

	// setup terms for a new line
	always_comb begin
		minor2 = {2'b00, cmd_minor, 1'b0};
		major2 = {2'b00, cmd_major, 1'b0};
	end

	// next pixel from the current state
	always_comb begin
		move_minor = !dec_q[DW-1];
		nx = cur_x_q;
		ny = cur_y_q;
		if (!y_major_q || move_minor) begin
			nx = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (y_major_q || move_minor) begin
			ny = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	// result write
	always_comb begin
		out_wr   = do_start || do_step;
		out_x    = do_start ? cmd_x : nx;
		out_y    = do_start ? cmd_y : ny;
		out_last = do_start ? (cmd_major == '0) : (steps_q == C'(1));
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			steps_q    <= '0;
			dec_q      <= '0;
			inc_move_q <= '0;
			inc_stay_q <= '0;
			x_neg_q    <= 1'b0;
			y_neg_q    <= 1'b0;
			y_major_q  <= 1'b0;
		end else if (do_start) begin
			busy_q     <= (cmd_major != '0);
			cur_x_q    <= cmd_x;
			cur_y_q    <= cmd_y;
			steps_q    <= cmd_major;
			dec_q      <= minor2 - {3'b000, cmd_major};
			inc_move_q <= minor2 - major2;
			inc_stay_q <= minor2;
			x_neg_q    <= cmd_ctrl.x_neg;
			y_neg_q    <= cmd_ctrl.y_neg;
			y_major_q  <= cmd_ctrl.y_major;
		end else if (do_step) begin
			busy_q  <= (steps_q != C'(1));
			cur_x_q <= nx;
			cur_y_q <= ny;
			steps_q <= steps_q - 1'b1;
			dec_q   <= dec_q + (move_minor ? inc_move_q : inc_stay_q);
		end
	end

	// engine checks
	a_busy_has_steps: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (steps_q != '0))
		else $error("busy with no pixels left");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_wr |-> !out_full)
		else $error("result written into a full queue");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_wr && out_last) |=> !busy_q)
		else $error("engine still busy after end pixel");

	a_busy_after_long_start: assert property (@(posedge clk) disable iff (!arst_n)
		(do_start && (cmd_major != '0)) |=> (busy_q && (steps_q == $past(cmd_major))))
		else $error("line setup lost");

endmodule

/* rtl/midpoint_line_rasterizer.sv */
// top level of the midpoint line rasterizer
`timescale 1ns / 1ps

// Midpoint line rasterizer, all octants.
// Input channel: push/full. An item is taken at a clock edge with push high and
// full low. req_type selects start (load endpoints, emit first pixel) or step
// (emit next pixel). A step with no line in progress produces no result; a
// start during a line drops the old line.
// Result channel: empty/pop. pixel_x, pixel_y and last show the oldest waiting
// result while empty is low; it is taken at an edge with pop high.
// Items enter a four-entry command queue after setup in the front end; the
// line engine takes one command per cycle, while the result queue has room,
// into a two-entry result queue. A result is registered in the result queue
// and can then be popped. Throughput: one item and one pixel per cycle while
// the receiver keeps up, bounded by the decision update in the line engine.
// When the receiver stalls, the result queue fills, the engine holds, and the
// command queue absorbs up to four more items before full rises.
// Reset clears both queues and leaves the engine idle.
module midpoint_line_rasterizer
	import mlr_pkg::*;
#(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	output logic                  empty,
	input  logic                  pop,
	output logic [COORD_BITS-1:0] pixel_x,
	output logic [COORD_BITS-1:0] pixel_y,
	output logic                  last
);

	localparam int C       = COORD_BITS;
	localparam int CMD_W   = CMD_CTRL_BITS + 4 * C;
	localparam int RES_W   = 2 * C + 1;

	cmd_ctrl_t    f_ctrl;
	logic [C-1:0] f_x;
	logic [C-1:0] f_y;
	logic [C-1:0] f_major;
	logic [C-1:0] f_minor;

	logic [CMD_W-1:0] cmd_rd;
	logic             cmd_empty;
	logic             cmd_pop;
	cmd_ctrl_t        b_ctrl;
	logic [C-1:0]     b_x;
	logic [C-1:0]     b_y;
	logic [C-1:0]     b_major;
	logic [C-1:0]     b_minor;

	logic         out_full;
	logic         out_wr;
	logic [C-1:0] out_x;
	logic [C-1:0] out_y;
	logic         out_last;

	// request setup
	mlr_front #(.COORD_BITS(C)) u_front (
		.req_type  (req_type),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.cmd_ctrl  (f_ctrl),
		.cmd_x     (f_x),
		.cmd_y     (f_y),
		.cmd_major (f_major),
		.cmd_minor (f_minor)
	);

	// command queue between front end and line engine
	mlr_fifo #(.WIDTH(CMD_W), .DEPTH(4)) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data ({f_ctrl, f_x, f_y, f_major, f_minor}),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rd),
		.full    (full),
		.empty   (cmd_empty)
	);

	assign {b_ctrl, b_x, b_y, b_major, b_minor} = cmd_rd;

	// line engine
	mlr_back #(.COORD_BITS(C)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.cmd_ctrl  (b_ctrl),
		.cmd_x     (b_x),
		.cmd_y     (b_y),
		.cmd_major (b_major),
		.cmd_minor (b_minor),
		.out_full  (out_full),
		.out_wr    (out_wr),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_last  (out_last)
	);

	// result queue
	mlr_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_wr),
		.wr_data ({out_x, out_y, out_last}),
		.rd_en   (pop),
		.rd_data ({pixel_x, pixel_y, last}),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

/* tb/tb.sv */
// testbench for the midpoint line rasterizer: directed lines, then random lines
`timescale 1ns / 1ps

module tb;
	import mlr_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int COORD_MIN = -2048;
	localparam int COORD_MAX = 2047;
	localparam int PIXEL_TARGET = 1250;
	localparam int DRAIN_EVERY = 400;
	localparam int QUIET_LIMIT = 400;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_PRINTED = 40;
	localparam int DIR_ROWS = 25;

	// one input item as driven on the ports
	typedef struct packed {
		req_t                  req;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
	} line_cmd_t;

	// one emitted pixel
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  lst;
	} pixel_t;

	// directed row: an item and, where obvious, the pixel it must give
	typedef struct packed {
		req_t req;
		int   sx;
		int   sy;
		int   ex;
		int   ey;
		bit   typed;
		bit   has_pix;
		int   px;
		int   py;
		bit   lst;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	logic                  req_type;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic                  empty;
	logic                  pop;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic                  last;

	pixel_t pix_expect_q[$];
	int     err_count = 0;
	int     pixel_items;
	int     quiet_cycles = 0;
	int     pop_hold = 0;
	bit     idle_en;

	// predictor copy of the line engine state
	logic                         ln_busy;
	logic [COORD_BITS-1:0]        ln_x;
	logic [COORD_BITS-1:0]        ln_y;
	logic [COORD_BITS:0]          ln_left;
	logic signed [COORD_BITS+2:0] ln_dec;
	logic [COORD_BITS-1:0]        ln_major;
	logic [COORD_BITS-1:0]        ln_minor;
	logic                         ln_xneg;
	logic                         ln_yneg;
	logic                         ln_ymaj;

	// directed lines: idle steps, degenerate, extremes, restart, octants, tie
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{REQ_STEP,  2047, -2048, 2047, -2048, 1'b1, 1'b0,     0,     0, 1'b0},
		'{REQ_START,    0,     0,    0,     0, 1'b1, 1'b1,     0,     0, 1'b1},
		'{REQ_STEP,    -1,    -1,   -1,    -1, 1'b1, 1'b0,     0,     0, 1'b0},
		'{REQ_START, -2048, -2048, 2047,  2047, 1'b1, 1'b1, -2048, -2048, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,  -2048, 2047, -2048, 2047, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_START,  2047, -2048, -2048, 2047, 1'b1, 1'b1,  2047, -2048, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_START,  2047,  2047, 2047, -2048, 1'b1, 1'b1,  2047,  2047, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_START,     5,     5,    6,     5, 1'b1, 1'b1,     5,     5, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b1, 1'b1,     6,     5, 1'b1},
		'{REQ_STEP,     0,     0,    0,     0, 1'b1, 1'b0,     0,     0, 1'b0},
		'{REQ_START,     0,     0,   -3,    -7, 1'b1, 1'b1,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b1, 1'b1,    -3,    -7, 1'b1},
		'{REQ_START,    10,     0,    7,     3, 1'b1, 1'b1,    10,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b0, 1'b0,     0,     0, 1'b0},
		'{REQ_STEP,     0,     0,    0,     0, 1'b1, 1'b1,     7,     3, 1'b1}
	};

	midpoint_line_rasterizer #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req_type(req_type),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.empty   (empty),
		.pop     (pop),
		.pixel_x (pixel_x),
		.pixel_y (pixel_y),
		.last    (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// next pixel of the line for one accepted item; returns 0 when nothing is emitted
	function automatic bit trace_pixel(input line_cmd_t c, output pixel_t px);
		int dx, dy, mj, mn, dnext;
		bit go_minor;
		logic [COORD_BITS-1:0] xs, ys;
		px = '0;
		if (c.req == REQ_START) begin
			dx = int'($signed(c.ex)) - int'($signed(c.sx));
			dy = int'($signed(c.ey)) - int'($signed(c.sy));
			ln_xneg = dx < 0;
			ln_yneg = dy < 0;
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			// ties go to x
			ln_ymaj = dy > dx;
			mj = ln_ymaj ? dy : dx;
			mn = ln_ymaj ? dx : dy;
			ln_major = COORD_BITS'(mj);
			ln_minor = COORD_BITS'(mn);
			ln_dec = (COORD_BITS+3)'(2 * mn - mj);
			ln_left = (COORD_BITS+1)'(mj);
			ln_x = c.sx;
			ln_y = c.sy;
			ln_busy = ln_left != 0;
			px = '{ln_x, ln_y, !ln_busy};
			return 1'b1;
		end
		// a step with no line in progress is dropped
		if (!ln_busy)
			return 1'b0;
		xs = ln_xneg ? '1 : COORD_BITS'(1);
		ys = ln_yneg ? '1 : COORD_BITS'(1);
		go_minor = ln_dec >= 0;
		if (go_minor)
			dnext = int'(ln_dec) + 2 * (int'(ln_minor) - int'(ln_major));
		else
			dnext = int'(ln_dec) + 2 * int'(ln_minor);
		ln_dec = (COORD_BITS+3)'(dnext);
		if (ln_ymaj) begin
			ln_y = ln_y + ys;
			if (go_minor) ln_x = ln_x + xs;
		end else begin
			ln_x = ln_x + xs;
			if (go_minor) ln_y = ln_y + ys;
		end
		ln_left = ln_left - 1'b1;
		ln_busy = ln_left != 0;
		px = '{ln_x, ln_y, !ln_busy};
		return 1'b1;
	endfunction

	function automatic line_cmd_t to_cmd(input req_t r, input int sx, input int sy,
			input int ex, input int ey);
		return '{r, COORD_BITS'(sx), COORD_BITS'(sy), COORD_BITS'(ex), COORD_BITS'(ey)};
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, 4095)) + COORD_MIN;
	endfunction

	function automatic int clamp_coord(input int v);
		return (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
	endfunction

	// bias some start points toward the edges of the coordinate range
	function automatic int pick_coord();
		if ($urandom_range(0, 3) != 0)
			return rand_coord();
		if ($urandom_range(0, 1) == 1)
			return COORD_MAX - int'($urandom_range(0, 7));
		return COORD_MIN + int'($urandom_range(0, 7));
	endfunction

	task automatic report_mismatch(input string what);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// compare one popped pixel against the oldest expected one
	task automatic check_pixel();
		pixel_t want;
		if (pix_expect_q.size() == 0) begin
			report_mismatch($sformatf("unexpected pixel (%0d,%0d) last=%0b",
				$signed(pixel_x), $signed(pixel_y), last));
			return;
		end
		want = pix_expect_q.pop_front();
		if (pixel_x !== want.x)
			report_mismatch($sformatf("pixel_x got %0d want %0d",
				$signed(pixel_x), $signed(want.x)));
		if (pixel_y !== want.y)
			report_mismatch($sformatf("pixel_y got %0d want %0d",
				$signed(pixel_y), $signed(want.y)));
		if (last !== want.lst)
			report_mismatch($sformatf("last got %0b want %0b at (%0d,%0d)",
				last, want.lst, $signed(want.x), $signed(want.y)));
	endtask

	// hand one item over, with an optional idle burst first
	task automatic send_item(input line_cmd_t c, output bit made, output pixel_t px);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push     <= 1'b1;
		req_type <= c.req;
		start_x  <= c.sx;
		start_y  <= c.sy;
		end_x    <= c.ex;
		end_y    <= c.ey;
		do @(posedge clk); while (full);
		made = trace_pixel(c, px);
	endtask

	task automatic send_and_expect(input line_cmd_t c);
		bit made;
		pixel_t px;
		send_item(c, made, px);
		if (made) begin
			pix_expect_q.push_back(px);
			pixel_items++;
		end
	endtask

	// hold the sender until every expected pixel is out
	task automatic drain_pixels();
		push <= 1'b0;
		do @(posedge clk); while (pix_expect_q.size() != 0);
	endtask

	// one random line: a start, then steps to the end, past it, or cut short
	task automatic run_random_line();
		int mode, span, sx, sy, ex, ey, adx, ady, major, n_steps;
		mode = $urandom_range(0, 19);
		sx = pick_coord();
		sy = pick_coord();
		span = ($urandom_range(0, 3) == 0) ? 40 : 12;
		ex = clamp_coord(sx + int'($urandom_range(0, 2 * span)) - span);
		ey = clamp_coord(sy + int'($urandom_range(0, 2 * span)) - span);
		// vertical, horizontal, diagonal, and far endpoints
		if (mode == 14) begin
			ex = sx;
		end else if (mode == 15) begin
			ey = sy;
		end else if (mode == 16) begin
			ex = clamp_coord(sx + (ey - sy));
		end else if (mode >= 17) begin
			ex = rand_coord();
			ey = rand_coord();
		end
		adx = (ex > sx) ? ex - sx : sx - ex;
		ady = (ey > sy) ? ey - sy : sy - ey;
		major = (adx > ady) ? adx : ady;
		if (mode >= 17)
			n_steps = $urandom_range(0, 24);
		else if ($urandom_range(0, 9) == 0)
			n_steps = $urandom_range(0, major);
		else if ($urandom_range(0, 3) == 0)
			n_steps = major + int'($urandom_range(1, 2));
		else
			n_steps = major;
		send_and_expect(to_cmd(REQ_START, sx, sy, ex, ey));
		repeat (n_steps)
			send_and_expect(to_cmd(REQ_STEP, rand_coord(), rand_coord(), rand_coord(),
				rand_coord()));
	endtask

	// result side: check on each pop, stall in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_pixel();
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				pop_hold = $urandom_range(0, 18);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// stimulus
	initial begin
		line_cmd_t c;
		bit made;
		pixel_t px;
		int next_drain;
		pixel_items = 0;
		idle_en = 1'b1;
		ln_busy = 1'b0;
		ln_x = '0;
		ln_y = '0;
		ln_left = '0;
		ln_dec = '0;
		ln_major = '0;
		ln_minor = '0;
		ln_xneg = 1'b0;
		ln_yneg = 1'b0;
		ln_ymaj = 1'b0;
		arst_n   <= 1'b0;
		push     <= 1'b0;
		req_type <= 1'b0;
		start_x  <= '0;
		start_y  <= '0;
		end_x    <= '0;
		end_y    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (dir_rows[i]) begin
			c = to_cmd(dir_rows[i].req, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
				dir_rows[i].ey);
			send_item(c, made, px);
			if (dir_rows[i].typed) begin
				if (dir_rows[i].has_pix)
					pix_expect_q.push_back('{COORD_BITS'(dir_rows[i].px),
						COORD_BITS'(dir_rows[i].py), dir_rows[i].lst});
			end else if (made) begin
				pix_expect_q.push_back(px);
			end
		end
		drain_pixels();

		// random lines, idling in some phases and none near the end
		pixel_items = 0;
		next_drain = DRAIN_EVERY;
		while (pixel_items < PIXEL_TARGET) begin
			idle_en = (pixel_items < PIXEL_TARGET - 250) && ((pixel_items / 150) % 3 != 2);
			run_random_line();
			if (pixel_items >= next_drain) begin
				drain_pixels();
				next_drain += DRAIN_EVERY;
			end
		end
		idle_en = 1'b0;

		// wait out the remaining pixels and any idle steps still in flight
		drain_pixels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0 && pix_expect_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
